// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the raster-to-tile swizzle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rts_pkg.sv =====
// Shared types, constants and helpers of the raster-to-tile swizzle.
package rts_pkg;

	// Line store geometry
	localparam int MAX_ROW_WORDS = 256;
	localparam int COL_W = $clog2(MAX_ROW_WORDS);
	localparam int STORE_ROWS = 3;
	localparam int STORE_DEPTH = STORE_ROWS * MAX_ROW_WORDS;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// Data widths
	localparam int WORD_W = 64;
	localparam int PIX_W = 32;
	localparam int HALF_W = 16;
	localparam int ROW_WORDS_W = 9;
	localparam int LEN_W = (COL_W + 1 > ROW_WORDS_W) ? COL_W + 1 : ROW_WORDS_W;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_WORDS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TILE_MODE = 1'd1;

	// Tile modes
	localparam logic MODE_PLAIN = 1'b0;
	localparam logic MODE_SPLIT = 1'b1;

	// Output queue
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	// Output word operations
	typedef logic [2:0] op_kind_t;
	localparam op_kind_t OP_PLAIN_MEM = 3'd0;
	localparam op_kind_t OP_PLAIN_DIR = 3'd1;
	localparam op_kind_t OP_PAIR_MEM = 3'd2;
	localparam op_kind_t OP_PAIR_DIR = 3'd3;
	localparam op_kind_t OP_LOW = 3'd4;

	typedef struct packed {
		logic valid;
		op_kind_t kind;
		logic [1:0] idx;
		logic last;
		logic [WORD_W-1:0] dir_a;
		logic [WORD_W-1:0] dir_b;
	} rts_op_t;

	typedef struct packed {
		logic [ROW_WORDS_W-1:0] row_words;
		logic tile_mode;
	} rts_cfg_t;

	// Gather upper or lower 16-bit halves of the four 32-bit pixels in a and b
	function automatic logic [WORD_W-1:0] halves(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic upper);
		int unsigned sh;
		sh = upper ? HALF_W : 0;
		halves = {a[PIX_W + sh +: HALF_W], a[sh +: HALF_W],
			b[PIX_W + sh +: HALF_W], b[sh +: HALF_W]};
	endfunction

endpackage

// ===== rtl/core/raster_to_tile_swizzle.sv =====
// Top level: a fourth-row word emits 4 words (plain) or an odd one 8 words (split).
// Each output word is registered in the sequencer, the assembly stage and the queue.
// Throughput: rows 0 to 2 take one word per cycle while no run is busy; a run holds
// the source until its last word issues, one word per cycle while the queue has room.
// Reset: position returns to row 0 column 0, row_words to 1 and tile_mode to 0;
// the line store is not cleared and needs no clearing pass.
module raster_to_tile_swizzle import rts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [ROW_WORDS_W-1:0] cfg_wdata,
	input logic s_tvalid,
	output logic s_tready,
	input logic [WORD_W-1:0] s_tdata, // [63:0] source_word
	input logic s_tuser, // [0] frame_start
	output logic m_tvalid,
	input logic m_tready,
	output logic [WORD_W-1:0] m_tdata, // [63:0] out_word
	output logic m_tlast
);

	rts_cfg_t cfg_q;
	rts_op_t op;
	logic room;
	logic wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [WORD_W-1:0] rd_data_a;
	logic [WORD_W-1:0] rd_data_b;
	logic push_valid;
	logic [WORD_W-1:0] push_word;
	logic push_last;
	logic [CNT_W-1:0] cnt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_words <= ROW_WORDS_W'(1);
			cfg_q.tile_mode <= MODE_PLAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_WORDS: cfg_q.row_words <= cfg_wdata;
				REG_TILE_MODE: cfg_q.tile_mode <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Issue a word only when the queue can take it and the one in flight
	assign room = (cnt + CNT_W'(push_valid)) < CNT_W'(OUT_DEPTH);

	rts_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.room(room),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.op(op)
	);

	rts_line_store u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	rts_asm u_asm (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.push_valid(push_valid),
		.push_word(push_word),
		.push_last(push_last)
	);

	rts_out_fifo u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_word(push_word),
		.push_last(push_last),
		.cnt(cnt),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

endmodule

// ===== rtl/core/rts_line_store.sv =====
// Line store: three rows of words, one write port and two registered read ports.
module rts_line_store import rts_pkg::*; (
	input logic clk,
	input logic wr_en,
	input logic [ADDR_W-1:0] wr_addr,
	input logic [WORD_W-1:0] wr_data,
	input logic rd_en,
	input logic [ADDR_W-1:0] rd_addr_a,
	input logic [ADDR_W-1:0] rd_addr_b,
	output logic [WORD_W-1:0] rd_data_a,
	output logic [WORD_W-1:0] rd_data_b
);

	logic [WORD_W-1:0] mem [STORE_DEPTH];

	// Write row data, read both tile columns
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/core/rts_seq.sv =====
// Position tracking, line store writes and output word sequencing.
`include "assert_macros.svh"
module rts_seq import rts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rts_cfg_t cfg,
	input logic s_tvalid,
	output logic s_tready,
	input logic [WORD_W-1:0] s_tdata,
	input logic s_tuser,
	input logic room,
	output logic wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [WORD_W-1:0] wr_data,
	output logic rd_en,
	output logic [ADDR_W-1:0] rd_addr_a,
	output logic [ADDR_W-1:0] rd_addr_b,
	output rts_op_t op
);

	localparam logic [1:0] BAND_LAST = 2'd3;
	localparam logic [2:0] STEP_PAIRS = 3'd3;
	localparam logic [2:0] STEP_PLAIN_END = 3'd3;
	localparam logic [2:0] STEP_SPLIT_END = 3'd7;

	function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] row,
			input logic [COL_W-1:0] col);
		store_addr = ADDR_W'(row) * ADDR_W'(MAX_ROW_WORDS) + ADDR_W'(col);
	endfunction

	// Stream position and held word
	logic [COL_W-1:0] col_q;
	logic [1:0] band_q;
	logic [WORD_W-1:0] held_q;

	// Transaction under sequencing
	logic busy_q;
	logic [2:0] step_q;
	logic mode_q;
	logic [COL_W-1:0] icol_q;
	logic [WORD_W-1:0] iword_q;
	logic [WORD_W-1:0] iheld_q;

	logic [LEN_W-1:0] len;
	logic [COL_W-1:0] cur_col;
	logic [1:0] cur_band;
	logic end_row;
	logic accept;
	logic starts;
	logic issue;
	logic last_step;

	// Effective row length
	always_comb begin
		if (cfg.row_words == '0 || LEN_W'(cfg.row_words) > LEN_W'(MAX_ROW_WORDS)) begin
			len = LEN_W'(MAX_ROW_WORDS);
		end else begin
			len = LEN_W'(cfg.row_words);
		end
	end

	// Position of the incoming transaction after an optional frame restart
	assign cur_col = s_tuser ? '0 : col_q;
	assign cur_band = s_tuser ? '0 : band_q;
	assign end_row = (LEN_W'(cur_col) + LEN_W'(1)) >= len;

	assign last_step = (mode_q == MODE_SPLIT) ? (step_q == STEP_SPLIT_END)
		: (step_q == STEP_PLAIN_END);
	assign issue = busy_q && room;
	assign s_tready = !busy_q || (issue && last_step);
	assign accept = s_tvalid && s_tready;
	assign starts = accept && cur_band == BAND_LAST
		&& (cfg.tile_mode == MODE_PLAIN || cur_col[0]);

	// Advance position and held word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			band_q <= '0;
		end else if (accept) begin
			if (end_row) begin
				col_q <= '0;
				band_q <= cur_band + 2'd1;
			end else begin
				col_q <= cur_col + COL_W'(1);
				band_q <= cur_band;
			end
		end
	end

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= starts;
			step_q <= '0;
		end else if (issue) begin
			busy_q <= !last_step;
			step_q <= step_q + 3'd1;
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= cfg.tile_mode;
			icol_q <= cur_col;
			iword_q <= s_tdata;
			iheld_q <= held_q;
			if (cur_band == BAND_LAST) begin
				held_q <= s_tdata;
			end
		end
	end

	// Store rows 0 to 2
	assign wr_en = accept && cur_band != BAND_LAST;
	assign wr_addr = store_addr(cur_band, cur_col);
	assign wr_data = s_tdata;

	// Read the tile column, even column too in split mode
	assign rd_en = issue && step_q < STEP_PAIRS;
	assign rd_addr_a = store_addr(step_q[1:0],
		(mode_q == MODE_SPLIT) ? (icol_q & ~COL_W'(1)) : icol_q);
	assign rd_addr_b = store_addr(step_q[1:0], icol_q);

	// Describe the output word of this step
	always_comb begin
		op.valid = issue;
		op.idx = step_q[1:0];
		op.last = last_step;
		op.dir_a = (mode_q == MODE_SPLIT) ? iheld_q : iword_q;
		op.dir_b = iword_q;
		if (mode_q == MODE_PLAIN) begin
			op.kind = (step_q < STEP_PAIRS) ? OP_PLAIN_MEM : OP_PLAIN_DIR;
		end else if (step_q < STEP_PAIRS) begin
			op.kind = OP_PAIR_MEM;
		end else if (step_q == STEP_PAIRS) begin
			op.kind = OP_PAIR_DIR;
		end else begin
			op.kind = OP_LOW;
		end
	end

	`ASSERT_IMPLIES(a_read_in_run, clk, arst_n, rd_en, busy_q && !last_step, "read outside a run")
	`ASSERT_IMPLIES(a_plain_steps, clk, arst_n, busy_q && mode_q == MODE_PLAIN, step_q <= STEP_PLAIN_END, "plain step overrun")
	`ASSERT_NEXT(a_start_run, clk, arst_n, starts, busy_q && step_q == '0, "run did not start")

endmodule

// ===== rtl/core/rts_asm.sv =====
// Output word assembly stage with the lower-half buffer of split tiles.
module rts_asm import rts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rts_op_t op,
	input logic [WORD_W-1:0] rd_data_a,
	input logic [WORD_W-1:0] rd_data_b,
	output logic push_valid,
	output logic [WORD_W-1:0] push_word,
	output logic push_last
);

	logic v_s1;
	rts_op_t op_s1;
	logic [WORD_W-1:0] lo_q [4];
	logic [WORD_W-1:0] pix_a;
	logic [WORD_W-1:0] pix_b;
	logic pair;

	// Hold the operation alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op;
	end

	// Pick pixel sources
	assign pix_a = (op_s1.kind == OP_PAIR_DIR) ? op_s1.dir_a : rd_data_a;
	assign pix_b = (op_s1.kind == OP_PAIR_DIR) ? op_s1.dir_b : rd_data_b;
	assign pair = op_s1.kind == OP_PAIR_MEM || op_s1.kind == OP_PAIR_DIR;

	// Build the output word
	always_comb begin
		case (op_s1.kind) inside
			OP_PLAIN_MEM: push_word = rd_data_a;
			OP_PLAIN_DIR: push_word = op_s1.dir_a;
			OP_PAIR_MEM, OP_PAIR_DIR: push_word = halves(pix_a, pix_b, 1'b1);
			OP_LOW: push_word = lo_q[op_s1.idx];
			default: push_word = '0;
		endcase
	end

	// Keep lower halves for the second pass
	always_ff @(posedge clk) begin
		if (v_s1 && pair) begin
			lo_q[op_s1.idx] <= halves(pix_a, pix_b, 1'b0);
		end
	end

	assign push_valid = v_s1;
	assign push_last = op_s1.last;

endmodule

// ===== rtl/core/rts_out_fifo.sv =====
// Output queue that decouples word assembly from the master stream.
`include "assert_macros.svh"
module rts_out_fifo import rts_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	input logic [WORD_W-1:0] push_word,
	input logic push_last,
	output logic [CNT_W-1:0] cnt,
	output logic m_tvalid,
	input logic m_tready,
	output logic [WORD_W-1:0] m_tdata,
	output logic m_tlast
);

	logic [WORD_W:0] buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic pop;

	assign pop = m_tvalid && m_tready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_valid) - CNT_W'(pop);
		end
	end

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push_valid) begin
			buf_q[wr_ptr_q] <= {push_last, push_word};
		end
	end

	assign cnt = cnt_q;
	assign m_tvalid = cnt_q != '0;
	assign m_tdata = buf_q[rd_ptr_q][WORD_W-1:0];
	assign m_tlast = buf_q[rd_ptr_q][WORD_W];

	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, push_valid && !pop, cnt_q != CNT_W'(OUT_DEPTH), "output queue overflow")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the raster-to-tile swizzle: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;
	import rts_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 12;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic last;
	} tile_word_t;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic [ROW_WORDS_W-1:0] rw;
		logic mode;
		logic [WORD_W-1:0] word;
		logic fs;
		logic lit;
		logic [3:0] lit_n;
		logic [3:0][WORD_W-1:0] lit_w;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [ROW_WORDS_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [WORD_W-1:0] s_tdata; // [63:0] source_word
	logic s_tuser; // [0] frame_start
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata; // [63:0] out_word
	logic m_tlast;

	// Predictor state and its copy of the registers
	logic [WORD_W-1:0] line_store [STORE_ROWS][MAX_ROW_WORDS];
	logic [WORD_W-1:0] held_word;
	logic [COL_W-1:0] col_pos;
	logic [1:0] band_row;
	logic [ROW_WORDS_W-1:0] row_len_cfg;
	logic mode_cfg;

	tile_word_t tiled_q [$];
	dir_step_t dir_steps [$];
	int errors = 0;
	int quiet_cycles = 0;
	int src_idle;
	int snk_stall;

	raster_to_tile_swizzle i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective row length: zero or oversize acts as the full store width
	function automatic int eff_row_len(input logic [ROW_WORDS_W-1:0] rw);
		if (rw == 0 || int'(rw) > MAX_ROW_WORDS)
			return MAX_ROW_WORDS;
		return int'(rw);
	endfunction

	// Gather upper or lower 16-bit halves of the four pixels held in a and b
	function automatic logic [WORD_W-1:0] pick_halves(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b, input logic upper);
		int sh;
		logic [HALF_W-1:0] a_hi, a_lo, b_hi, b_lo;
		sh = upper ? HALF_W : 0;
		a_hi = HALF_W'(a >> (PIX_W + sh));
		a_lo = HALF_W'(a >> sh);
		b_hi = HALF_W'(b >> (PIX_W + sh));
		b_lo = HALF_W'(b >> sh);
		return {a_hi, a_lo, b_hi, b_lo};
	endfunction

	// Compute the tiled words released by one source word and advance position
	task automatic predict_tiles(input logic [WORD_W-1:0] w, input logic fs,
			output tile_word_t run [8], output int n);
		int len;
		logic [WORD_W-1:0] ea [4];
		logic [WORD_W-1:0] ob [4];
		len = eff_row_len(row_len_cfg);
		n = 0;
		if (fs) begin
			col_pos = '0;
			band_row = '0;
		end
		if (band_row < 3) begin
			line_store[band_row][col_pos] = w;
		end else if (mode_cfg == MODE_PLAIN) begin
			for (int k = 0; k < 3; k++)
				run[k] = '{line_store[k][col_pos], 1'b0};
			run[3] = '{w, 1'b1};
			n = 4;
			held_word = w;
		end else begin
			// Split tile: only the odd column of a pair completes it
			if (col_pos[0]) begin
				for (int k = 0; k < 3; k++) begin
					ea[k] = line_store[k][col_pos - 1'b1];
					ob[k] = line_store[k][col_pos];
				end
				ea[3] = held_word;
				ob[3] = w;
				for (int k = 0; k < 4; k++) begin
					run[k] = '{pick_halves(ea[k], ob[k], 1'b1), 1'b0};
					run[4 + k] = '{pick_halves(ea[k], ob[k], 1'b0), 1'b0};
				end
				run[7].last = 1'b1;
				n = 8;
			end
			held_word = w;
		end
		if (int'(col_pos) + 1 >= len) begin
			col_pos = '0;
			band_row = band_row + 2'd1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// Offer one source word, wait for its transaction, queue what it releases
	task automatic send_word(input logic [WORD_W-1:0] word, input logic fs,
			input logic lit, input int lit_n, input logic [3:0][WORD_W-1:0] lit_w);
		tile_word_t run [8];
		int n;
		if (src_idle != 0 && $urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= fs;
		do @(posedge clk); while (!s_tready);
		predict_tiles(word, fs, run, n);
		if (lit) begin
			for (int k = 0; k < lit_n; k++)
				tiled_q.push_back('{lit_w[k], k == lit_n - 1});
		end else begin
			for (int k = 0; k < n; k++)
				tiled_q.push_back(run[k]);
		end
	endtask

	// Hold the source side until every queued word has come out
	task automatic drain_results(input int hold);
		s_tvalid <= 1'b0;
		while (tiled_q.size() != 0)
			@(posedge clk);
		repeat (hold) @(posedge clk);
	endtask

	// Write both registers on back-to-back cycles
	task automatic write_config(input logic [ROW_WORDS_W-1:0] rw, input logic mode);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_WORDS;
		cfg_wdata <= rw;
		@(posedge clk);
		cfg_index <= REG_TILE_MODE;
		cfg_wdata <= ROW_WORDS_W'(mode);
		@(posedge clk);
		cfg_we <= 1'b0;
		row_len_cfg = rw;
		mode_cfg = mode;
	endtask

	function automatic dir_step_t item_step(input logic [WORD_W-1:0] word, input logic fs);
		dir_step_t s;
		s = '0;
		s.kind = STEP_ITEM;
		s.word = word;
		s.fs = fs;
		return s;
	endfunction

	function automatic dir_step_t lit_step(input logic [WORD_W-1:0] word, input logic fs,
			input int n, input logic [3:0][WORD_W-1:0] words);
		dir_step_t s;
		s = item_step(word, fs);
		s.lit = 1'b1;
		s.lit_n = 4'(n);
		s.lit_w = words;
		return s;
	endfunction

	function automatic dir_step_t cfg_step(input logic [ROW_WORDS_W-1:0] rw, input logic mode);
		dir_step_t s;
		s = '0;
		s.kind = STEP_CFG;
		s.rw = rw;
		s.mode = mode;
		return s;
	endfunction

	// Random backpressure on the master side
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= snk_stall);

	// Compare each output transaction with the oldest queued word
	always @(posedge clk) begin
		tile_word_t exp_w;
		if (arst_n && m_tvalid && m_tready) begin
			if (tiled_q.size() == 0) begin
				$error("unexpected output word %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				exp_w = tiled_q.pop_front();
				if (m_tdata !== exp_w.word) begin
					$error("out_word mismatch: expected %h, got %h", exp_w.word, m_tdata);
					errors++;
				end
				if (m_tlast !== exp_w.last) begin
					$error("last mismatch: expected %b, got %b", exp_w.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog: end the run after too long without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[raster_to_tile_swizzle] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ROW_WORDS_W-1:0] phase_rw [PHASES];
		logic phase_mode [PHASES];
		int eff, target, frame_left;
		logic fs;

		phase_rw = '{9'd4, 9'd2, 9'd8, 9'd5, 9'd1, 9'd3, 9'd6, 9'd0, 9'd256, 9'd511,
			9'd16, 9'd12};
		phase_mode = '{MODE_PLAIN, MODE_SPLIT, MODE_SPLIT, MODE_PLAIN, MODE_SPLIT,
			MODE_SPLIT, MODE_PLAIN, MODE_PLAIN, MODE_SPLIT, MODE_PLAIN, MODE_SPLIT,
			MODE_PLAIN};

		src_idle = 0;
		snk_stall = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		held_word = '0;
		col_pos = '0;
		band_row = '0;
		row_len_cfg = ROW_WORDS_W'(1);
		mode_cfg = MODE_PLAIN;

		// Directed table; literal words listed {w3, w2, w1, w0}
		// Reset config: one-word rows, plain tiles
		dir_steps.push_back(item_step(64'h0, 1'b1));
		dir_steps.push_back(item_step('1, 1'b0));
		dir_steps.push_back(item_step(64'h5555_5555_5555_5555, 1'b0));
		dir_steps.push_back(lit_step(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 4,
			{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0}));
		// Split tiles, two-word rows: one 4x4 pixel tile
		dir_steps.push_back(cfg_step(9'd2, MODE_SPLIT));
		dir_steps.push_back(item_step(64'h0011_2233_4455_6677, 1'b1));
		dir_steps.push_back(item_step(64'h8899_AABB_CCDD_EEFF, 1'b0));
		dir_steps.push_back(item_step(64'hFFFF_0000_FFFF_0000, 1'b0));
		dir_steps.push_back(item_step(64'h0000_FFFF_0000_FFFF, 1'b0));
		dir_steps.push_back(item_step(64'h0123_4567_89AB_CDEF, 1'b0));
		dir_steps.push_back(item_step(64'hFEDC_BA98_7654_3210, 1'b0));
		dir_steps.push_back(item_step(64'hDEAD_BEEF_CAFE_F00D, 1'b0));
		dir_steps.push_back(item_step(64'h1357_9BDF_2468_ACE0, 1'b0));
		// Split tiles with an odd row: the unpaired word releases nothing
		dir_steps.push_back(cfg_step(9'd1, MODE_SPLIT));
		dir_steps.push_back(item_step(64'h1111_1111_1111_1111, 1'b1));
		dir_steps.push_back(item_step(64'h2222_2222_2222_2222, 1'b0));
		dir_steps.push_back(item_step(64'h3333_3333_3333_3333, 1'b0));
		dir_steps.push_back(lit_step(64'h4444_4444_4444_4444, 1'b0, 0, '0));
		// Row shortened mid-row: position past the new end closes the row
		dir_steps.push_back(cfg_step(9'd3, MODE_PLAIN));
		dir_steps.push_back(item_step(64'hA0A0_A0A0_A0A0_A0A0, 1'b1));
		dir_steps.push_back(item_step(64'hA1A1_A1A1_A1A1_A1A1, 1'b0));
		dir_steps.push_back(cfg_step(9'd1, MODE_PLAIN));
		dir_steps.push_back(item_step(64'hA2A2_A2A2_A2A2_A2A2, 1'b0));
		dir_steps.push_back(item_step(64'hB0B0_B0B0_B0B0_B0B0, 1'b0));
		dir_steps.push_back(item_step(64'hC0C0_C0C0_C0C0_C0C0, 1'b0));
		dir_steps.push_back(lit_step(64'hD0D0_D0D0_D0D0_D0D0, 1'b0, 4,
			{64'hD0D0_D0D0_D0D0_D0D0, 64'hC0C0_C0C0_C0C0_C0C0, 64'hB0B0_B0B0_B0B0_B0B0,
			64'hA0A0_A0A0_A0A0_A0A0}));

		// Release reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_steps[i]) begin
			if (dir_steps[i].kind == STEP_CFG) begin
				drain_results(SETTLE_CYCLES);
				write_config(dir_steps[i].rw, dir_steps[i].mode);
			end else begin
				send_word(dir_steps[i].word, dir_steps[i].fs, dir_steps[i].lit,
					int'(dir_steps[i].lit_n), dir_steps[i].lit_w);
			end
		end

		// Random frames, one register setting and one idle profile per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 70; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 70; end
				default: begin src_idle = 25; snk_stall = 25; end
			endcase
			drain_results(SETTLE_CYCLES);
			write_config(phase_rw[ph], phase_mode[ph]);
			eff = eff_row_len(phase_rw[ph]);
			// Full-width rows: a short stretch that stays inside the first row
			if (eff > 16)
				target = 24;
			else
				target = (4 * eff > 32) ? 4 * eff : 32;
			frame_left = 0;
			for (int i = 0; i < target; i++) begin
				if (i == target / 2)
					drain_results(0);
				fs = 1'b0;
				// Start a new frame, or break the current one now and then
				if (frame_left <= 0 || (eff <= 16 && $urandom_range(99) < 3)) begin
					fs = 1'b1;
					frame_left = $urandom_range(3, 1) * 4 * eff;
				end
				send_word({$urandom, $urandom}, fs, 1'b0, 0, '0);
				frame_left--;
			end
		end

		// Drain and finish
		drain_results(2 * SETTLE_CYCLES);
		if (errors == 0) begin
			$display("[raster_to_tile_swizzle] OK");
		end else begin
			$display("[raster_to_tile_swizzle] ERROR");
		end
		$finish;
	end

endmodule
